// File: hdl/mse_pkg.sv
// ---------------------------------------------------------------------------
// mse_pkg
// Types and constants shared by the mean squared error loss/gradient core.
// ---------------------------------------------------------------------------
package mse_pkg;

   localparam int DATA_W     = 16;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int INV_W      = 25;
   localparam int SUM_W      = 50;
   localparam int LOSS_W     = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [INV_W-1:0] INV_RESET = INV_W'(1) << (INV_W - 1);
   localparam logic [SUM_W-1:0] SUM_MAX   = '1;

   typedef struct packed {
      logic signed [DATA_W-1:0] pred_value;
      logic signed [DATA_W-1:0] target_value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gradient;
      logic                     loss_valid;
      logic [LOSS_W-1:0]        loss;
   } rsp_type;

   // queue entry: difference already formed by the front end
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff;
      logic                     last;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

// File: hdl/mse_front.sv
// ---------------------------------------------------------------------------
// mse_front
// Accepts request words, forms pred - target and pushes it into the queue.
// ---------------------------------------------------------------------------
module mse_front (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mse_pkg::req_type        req_data,
   input  mse_pkg::fifo_status_type fifo_status,
   output logic                    push,
   output mse_pkg::entry_type      push_entry
);
   import mse_pkg::*;

   always_comb begin
      req_ready       = !fifo_status.full;
      push            = req_valid && !fifo_status.full;
      // 17-bit difference, cannot overflow
      push_entry.diff = DIFF_W'(req_data.pred_value) - DIFF_W'(req_data.target_value);
      push_entry.last = req_data.last_element;
   end

endmodule

// File: hdl/mse_fifo.sv
// ---------------------------------------------------------------------------
// mse_fifo
// Small queue between the front end and the arithmetic back end.
// ---------------------------------------------------------------------------
module mse_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mse_pkg::entry_type       push_entry,
   input  logic                     pop,
   output mse_pkg::entry_type       head_entry,
   output mse_pkg::fifo_status_type status
);
   import mse_pkg::*;

   entry_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      head_entry   = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/mse_back.sv
// ---------------------------------------------------------------------------
// mse_back
// Gradient scaling, square accumulation and mean on the last element.
// ---------------------------------------------------------------------------
module mse_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mse_pkg::INV_W-1:0]  inv_count,
   input  mse_pkg::entry_type         head_entry,
   input  mse_pkg::fifo_status_type   fifo_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mse_pkg::rsp_type           rsp_data
);
   import mse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ACC  = 4'b0010,
      ST_LMUL = 4'b0100,
      ST_LADD = 4'b1000
   } back_state_type;

   localparam int PROD_W = DIFF_W + INV_W;      // d * inv, signed
   localparam int SQ_W   = 2 * DATA_W;          // d * d always fits
   localparam int HALF_W = SUM_W / 2;
   localparam int PART_W = HALF_W + INV_W;
   localparam int GW_W   = PROD_W - 23;
   localparam int R_W    = PART_W - 7 + 1;

   back_state_type              state_ff, state_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic [SQ_W-1:0]             sq_ff, sq_in;
   logic                        last_ff, last_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [PART_W-1:0]           hi_part_ff, hi_part_in;
   logic [PART_W-1:0]           lo_part_ff, lo_part_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic                        out_free;
   logic                        take;
   logic signed [2*DIFF_W-1:0]  sq_full;
   logic signed [PROD_W-1:0]    rounded;
   logic signed [GW_W-1:0]      grad_wide;
   logic signed [DATA_W-1:0]    grad_sat;
   logic [SUM_W:0]              sum_add;
   logic [SUM_W-1:0]            sum_sat;
   logic [PART_W+1:0]           inner;
   logic [R_W-1:0]              loss_wide;
   logic [LOSS_W-1:0]           loss_sat;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      take     = (state_ff == ST_IDLE) || ((state_ff == ST_ACC) && !last_ff && out_free);
      pop      = take && !fifo_status.empty;

      prod_in  = head_entry.diff * $signed({1'b0, inv_count});
      sq_full  = head_entry.diff * head_entry.diff;
      sq_in    = sq_full[SQ_W-1:0];

      // round(2*d*inv / 2^24), ties up
      rounded   = prod_ff + PROD_W'(1 << 22);
      grad_wide = rounded[PROD_W-1:23];
      if (grad_wide > GW_W'(32767)) begin
         grad_sat = 16'sh7fff;
      end else if (grad_wide < -GW_W'(32768)) begin
         grad_sat = 16'sh8000;
      end else begin
         grad_sat = grad_wide[DATA_W-1:0];
      end

      sum_add = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);
      sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

      // (sum * inv + 2^31) >> 32 from the two half products
      inner     = (PART_W+2)'({hi_part_ff[6:0], {INV_W{1'b0}}}) + (PART_W+2)'(lo_part_ff)
                  + (PART_W+2)'(64'd1 << 31);
      loss_wide = R_W'(hi_part_ff[PART_W-1:7]) + R_W'(inner[PART_W+1:32]);
      loss_sat  = (|loss_wide[R_W-1:LOSS_W]) ? '1 : loss_wide[LOSS_W-1:0];

      hi_part_in = sum_ff[SUM_W-1:HALF_W] * inv_count;
      lo_part_in = sum_ff[HALF_W-1:0] * inv_count;

      state_in     = state_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (last_ff) begin
               sum_in   = sum_sat;
               state_in = ST_LMUL;
            end else if (out_free) begin
               sum_in              = sum_sat;
               rsp_valid_in        = 1'b1;
               rsp_in.gradient     = grad_sat;
               rsp_in.loss_valid   = 1'b0;
               rsp_in.loss         = '0;
               state_in            = pop ? ST_ACC : ST_IDLE;
            end
         end
         ST_LMUL: begin
            sum_in   = '0;
            state_in = ST_LADD;
         end
         ST_LADD: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.gradient   = grad_sat;
               rsp_in.loss_valid = 1'b1;
               rsp_in.loss       = loss_sat;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pop) begin
         last_in = head_entry.last;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
      end
      if (state_ff == ST_LMUL) begin
         hi_part_ff <= hi_part_in;
         lo_part_ff <= lo_part_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/mse_loss_and_gradient_core.sv
// ---------------------------------------------------------------------------
// mse_loss_and_gradient_core
// Streams pred/target pairs, returns per-element gradient and final MSE.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one word per element (pred, target in signed Q4.12, last
//   flag). rsp channel: one word per request: gradient 2*(pred-target)/N in
//   Q4.12, and on the last element also the mean squared error in Q16.16.
//   csr_write_data sets 1/N (unsigned Q1.24); the user must write it only
//   while the block is idle, which the block itself does not enforce.
// Flow: an element passes the queue, the product and square registers and
//   the output register; the last element also passes the split 25x25
//   products of the running sum and their final add.
// Throughput: one element per cycle while the output is free, set by the
//   single accumulate stage; none is taken while a last element finishes.
// Reset: the running sum clears, 1/N returns to 1.0, the queue empties.
// Stall: the output register holds its word while rsp_ready is low; the
//   four-entry queue keeps taking requests until it fills, then req_ready
//   drops.
// ---------------------------------------------------------------------------
module mse_loss_and_gradient_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mse_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mse_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_enable,
   input  logic [mse_pkg::INV_W-1:0]  csr_write_data
);
   import mse_pkg::*;

   logic [INV_W-1:0] inv_count_ff;
   fifo_status_type  fifo_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_count_ff <= INV_RESET;
      end else if (csr_write_enable) begin
         inv_count_ff <= csr_write_data;
      end
   end

   mse_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   mse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (fifo_status)
   );

   mse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .inv_count   (inv_count_ff),
      .head_entry  (head_entry),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
